[design/hscd_pkg.sv]
package hscd_pkg;

    localparam int MAX_PADDED_COLS_DEF = 1024;
    localparam int DATA_WIDTH_DEF      = 32;
    localparam int FRAC_BITS_DEF       = 16;

    localparam int CFG_W = 31;

    localparam logic [30:0] STEP_RESET  = 31'd65536;
    localparam logic [9:0]  COLS_RESET  = 10'd16;
    localparam logic [15:0] ROWS_RESET  = 16'd16;

    typedef enum logic [2:0] {
        REG_STEP_X    = 3'd0,
        REG_STEP_Y    = 3'd1,
        REG_RATIO_XY  = 3'd2,
        REG_RATIO_YX  = 3'd3,
        REG_VOLUME    = 3'd4,
        REG_GRID_COLS = 3'd5,
        REG_GRID_ROWS = 3'd6
    } cfg_index_t;

endpackage

[design/hybrid_scheme_cd_residual_stencil.sv]
// The residual passes through seven register stages, line-store read included, on its way
// from the acceptance of its north-cell request to the output register.
// Throughput: one cell per cycle; the line stores (one write, two reads per cycle each)
// and the single-cycle multipliers of the flux and term stages set that rate.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears valid bits, counters and config registers to defaults;
// the line stores are not cleared and need no clearing pass.
module hybrid_scheme_cd_residual_stencil
    import hscd_pkg::*;
#(
    parameter int MAX_PADDED_COLS = MAX_PADDED_COLS_DEF,
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    localparam int CW    = $clog2(MAX_PADDED_COLS),
    localparam int IN_W  = ((5 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((DATA_WIDTH + CW + 16 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // scalar_value, vel_x, vel_y, diffusivity, source_term (lowest first)
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    // residual, centre_col, centre_row (lowest first); tlast = last_cell
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int LW  = 3 * DW;                       // scalar, vel_y, diffusivity
    localparam int RW  = 2 * DW;                       // vel_x, source
    localparam int AWD = CW + 1;                       // parity bit + column
    localparam int MEM_DEPTH = 2 * (2 ** CW);
    localparam int ROW_DEPTH = 2 ** CW;
    localparam int NX_MAX = MAX_PADDED_COLS - 2;
    localparam int FW  = DW + 32 - FB;                 // face flux / diffusion width
    localparam int AW  = FW + 2;                       // coefficient width
    localparam int TW  = (DW > 32) ? 2 * DW : DW + 32; // product width
    localparam int SATW = ((TW + 3 > AW + 3) ? TW + 3 : AW + 3) + 1;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [15:0]   row;
        logic          last;
    } meta_t;

    // ---------------------------------------------------------------- config
    logic [30:0] step_x_reg, step_y_reg, ratio_xy_reg, ratio_yx_reg, volume_reg;
    logic [9:0]  grid_cols_reg;
    logic [15:0] grid_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg    <= STEP_RESET;
            step_y_reg    <= STEP_RESET;
            ratio_xy_reg  <= STEP_RESET;
            ratio_yx_reg  <= STEP_RESET;
            volume_reg    <= STEP_RESET;
            grid_cols_reg <= COLS_RESET;
            grid_rows_reg <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_X:    step_x_reg    <= cfg_data;
                REG_STEP_Y:    step_y_reg    <= cfg_data;
                REG_RATIO_XY:  ratio_xy_reg  <= cfg_data;
                REG_RATIO_YX:  ratio_yx_reg  <= cfg_data;
                REG_VOLUME:    volume_reg    <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data[9:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ pipeline control
    // Whole pipeline moves together whenever the output register can take data.
    logic en, fire;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign fire     = s_tvalid && en;

    // -------------------------------------------------- stage 0: raster count
    logic [CW-1:0] col_reg, col_next;
    logic [16:0]   row_reg, row_next;
    logic [31:0]   gc32;
    logic [CW-1:0] nx;
    logic [CW:0]   w;
    logic [15:0]   ny;
    logic [16:0]   h;
    logic [CW-1:0] c;
    logic [16:0]   r;
    logic [16:0]   r_m1;
    logic          emit0;
    logic [AWD-1:0] addr_wr, addr_e, addr_s;
    logic [CW-1:0]  addr_xe;

    always_comb
    begin
        gc32 = 32'(grid_cols_reg);
        if (gc32 == 32'd0)
            nx = CW'(1);
        else if (gc32 > 32'(NX_MAX))
            nx = CW'(NX_MAX);
        else
            nx = CW'(gc32);
        w  = (CW + 1)'(nx) + (CW + 1)'(2);
        ny = (grid_rows_reg == 16'd0) ? 16'd1 : grid_rows_reg;
        h  = 17'(ny) + 17'd2;
        c  = ((CW + 1)'(col_reg) >= w) ? '0 : col_reg;
        r  = (row_reg >= h) ? '0 : row_reg;
        r_m1  = r - 17'd1;
        emit0 = (r >= 17'd2) && (c != '0) && (c <= nx);

        addr_wr = {r[0], c};
        addr_e  = {~r[0], c + CW'(1)};
        // column 0 never emits, so its south port fetches the west tap of the
        // centre row for the column 1 window
        if (c == '0)
            addr_s = {~r[0], c};
        else
            addr_s = {r[0], c};
        addr_xe = c + CW'(1);

        if ((CW + 1)'(c) + (CW + 1)'(1) >= w)
        begin
            col_next = '0;
            row_next = (r + 17'd1 >= h) ? '0 : r + 17'd1;
        end
        else
        begin
            col_next = c + CW'(1);
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // two padded rows by parity for scalar, vel_y and diffusivity;
    // one row by column for vel_x and source
    logic [LW-1:0] line_mem [MEM_DEPTH];
    logic [RW-1:0] row_mem  [ROW_DEPTH];
    logic [LW-1:0] rd_e_reg, rd_s_reg;
    logic [RW-1:0] rd_xc_reg, rd_xe_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_mem[addr_wr] <= {s_tdata[3*DW +: DW], s_tdata[2*DW +: DW], s_tdata[0 +: DW]};
            rd_e_reg <= line_mem[addr_e];
            rd_s_reg <= line_mem[addr_s];
            row_mem[c] <= {s_tdata[4*DW +: DW], s_tdata[1*DW +: DW]};
            rd_xc_reg <= row_mem[c];
            rd_xe_reg <= row_mem[addr_xe];
        end
    end

    // ------------------------------------------------ stage 1: read data back
    logic v1_reg, emit1_reg;
    meta_t meta1_reg;
    logic signed [DW-1:0] xn1_reg, vn1_reg, nn1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            emit1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= fire;
            emit1_reg <= fire && emit0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            meta1_reg.col  <= c;
            meta1_reg.row  <= r_m1[15:0];
            meta1_reg.last <= (r_m1 == 17'(ny)) && (c == nx);
            xn1_reg <= s_tdata[0*DW +: DW];
            vn1_reg <= s_tdata[2*DW +: DW];
            nn1_reg <= s_tdata[3*DW +: DW];
        end
    end

    // ------------------------------------------- stage 2: window and face sums
    // centre and west taps come from earlier east reads; the west vel_x is the
    // centre vel_x read of the previous request
    logic [LW-1:0] win_p_reg, win_w_reg;
    logic signed [DW-1:0] uw_hold_reg;

    always_ff @(posedge clk)
    begin
        if (en && v1_reg)
        begin
            win_p_reg   <= rd_e_reg;
            win_w_reg   <= (meta1_reg.col == '0) ? rd_s_reg : win_p_reg;
            uw_hold_reg <= rd_xc_reg[0 +: DW];
        end
    end

    logic signed [DW-1:0] xp, xw, xe, xs, ue, up, uw, vp, vs, np_, ne, nw, ns, srcp;

    always_comb
    begin
        xe = rd_e_reg[0*DW +: DW];
        ne = rd_e_reg[2*DW +: DW];
        xp = win_p_reg[0*DW +: DW];
        vp = win_p_reg[1*DW +: DW];
        np_ = win_p_reg[2*DW +: DW];
        xw = win_w_reg[0*DW +: DW];
        nw = win_w_reg[2*DW +: DW];
        xs = rd_s_reg[0*DW +: DW];
        vs = rd_s_reg[1*DW +: DW];
        ns = rd_s_reg[2*DW +: DW];
        up = rd_xc_reg[0*DW +: DW];
        srcp = rd_xc_reg[1*DW +: DW];
        ue = rd_xe_reg[0*DW +: DW];
        uw = uw_hold_reg;
    end

    logic v2_reg;
    meta_t meta2_reg;
    logic signed [DW:0] sfs_reg, sfn_reg, sfe_reg, sfw_reg;
    logic signed [DW:0] sds_reg, sdn_reg, sde_reg, sdw_reg;
    logic signed [DW-1:0] xs2_reg, xn2_reg, xe2_reg, xw2_reg, xp2_reg, src2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg && emit1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta2_reg <= meta1_reg;
            sfs_reg <= (DW + 1)'(vs) + (DW + 1)'(vp);
            sfn_reg <= (DW + 1)'(vn1_reg) + (DW + 1)'(vp);
            sfe_reg <= (DW + 1)'(ue) + (DW + 1)'(up);
            sfw_reg <= (DW + 1)'(uw) + (DW + 1)'(up);
            sds_reg <= (DW + 1)'(np_) + (DW + 1)'(ns);
            sdn_reg <= (DW + 1)'(np_) + (DW + 1)'(nn1_reg);
            sde_reg <= (DW + 1)'(np_) + (DW + 1)'(ne);
            sdw_reg <= (DW + 1)'(np_) + (DW + 1)'(nw);
            xs2_reg <= xs;
            xn2_reg <= xn1_reg;
            xe2_reg <= xe;
            xw2_reg <= xw;
            xp2_reg <= xp;
            src2_reg <= srcp;
        end
    end

    // ------------------------------------------ stage 3: fluxes and diffusion
    function automatic logic signed [FW-1:0] face_scale(input logic signed [DW:0] s,
                                                         input logic [30:0] k);
        logic signed [DW+32:0] prod;
        prod = (DW + 33)'(s) * (DW + 33)'($signed({2'b00, k}));
        return prod[FB+1 +: FW];
    endfunction

    logic v3_reg;
    meta_t meta3_reg;
    logic signed [FW-1:0] fs_reg, fn_reg, fe_reg, fw_reg, ds_reg, dn_reg, de_reg, dw_reg;
    logic signed [DW-1:0] xs3_reg, xn3_reg, xe3_reg, xw3_reg, xp3_reg, src3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta3_reg <= meta2_reg;
            fs_reg <= face_scale(sfs_reg, step_x_reg);
            fn_reg <= face_scale(sfn_reg, step_x_reg);
            fe_reg <= face_scale(sfe_reg, step_y_reg);
            fw_reg <= face_scale(sfw_reg, step_y_reg);
            ds_reg <= face_scale(sds_reg, ratio_xy_reg);
            dn_reg <= face_scale(sdn_reg, ratio_xy_reg);
            de_reg <= face_scale(sde_reg, ratio_yx_reg);
            dw_reg <= face_scale(sdw_reg, ratio_yx_reg);
            xs3_reg <= xs2_reg;
            xn3_reg <= xn2_reg;
            xe3_reg <= xe2_reg;
            xw3_reg <= xw2_reg;
            xp3_reg <= xp2_reg;
            src3_reg <= src2_reg;
        end
    end

    // ------------------------------------------- stage 4: hybrid coefficients
    function automatic logic signed [AW-1:0] max3(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] b);
        logic signed [AW-1:0] m;
        m = (a > b) ? a : b;
        return (m > 0) ? m : '0;
    endfunction

    logic signed [AW-1:0] a_s, a_n, a_e, a_w, fsum;

    always_comb
    begin
        a_s = max3(AW'(fs_reg), AW'(ds_reg) + AW'(fs_reg >>> 1));
        a_n = max3(-AW'(fn_reg), AW'(dn_reg) - AW'(fn_reg >>> 1));
        a_e = max3(-AW'(fe_reg), AW'(de_reg) - AW'(fe_reg >>> 1));
        a_w = max3(AW'(fw_reg), AW'(dw_reg) + AW'(fw_reg >>> 1));
        fsum = AW'(fe_reg) - AW'(fw_reg) + AW'(fn_reg) - AW'(fs_reg);
    end

    logic v4_reg;
    meta_t meta4_reg;
    logic signed [AW-1:0] as4_reg, an4_reg, ae4_reg, aw4_reg, fsum4_reg;
    logic signed [DW-1:0] xs4_reg, xn4_reg, xe4_reg, xw4_reg, xp4_reg, src4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta4_reg <= meta3_reg;
            as4_reg <= a_s;
            an4_reg <= a_n;
            ae4_reg <= a_e;
            aw4_reg <= a_w;
            fsum4_reg <= fsum;
            xs4_reg <= xs3_reg;
            xn4_reg <= xn3_reg;
            xe4_reg <= xe3_reg;
            xw4_reg <= xw3_reg;
            xp4_reg <= xp3_reg;
            src4_reg <= src3_reg;
        end
    end

    // ------------------------------------ stage 5: centre coefficient, clamps
    function automatic logic signed [DW-1:0] sat(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi, lo;
        hi = {{(SATW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[DW-1:0];
        else if (v < lo)
            return lo[DW-1:0];
        return v[DW-1:0];
    endfunction

    logic signed [AW+2:0] ap_sum;

    assign ap_sum = (AW + 3)'(fsum4_reg) + (AW + 3)'(as4_reg) + (AW + 3)'(an4_reg)
                  + (AW + 3)'(ae4_reg) + (AW + 3)'(aw4_reg);

    logic v5_reg;
    meta_t meta5_reg;
    logic signed [DW-1:0] as5_reg, an5_reg, ae5_reg, aw5_reg, ap5_reg;
    logic signed [DW-1:0] xs5_reg, xn5_reg, xe5_reg, xw5_reg, xp5_reg, src5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta5_reg <= meta4_reg;
            as5_reg <= sat(SATW'(as4_reg));
            an5_reg <= sat(SATW'(an4_reg));
            ae5_reg <= sat(SATW'(ae4_reg));
            aw5_reg <= sat(SATW'(aw4_reg));
            ap5_reg <= sat(SATW'(ap_sum));
            xs5_reg <= xs4_reg;
            xn5_reg <= xn4_reg;
            xe5_reg <= xe4_reg;
            xw5_reg <= xw4_reg;
            xp5_reg <= xp4_reg;
            src5_reg <= src4_reg;
        end
    end

    // ------------------------------------------------ stage 6: product terms
    function automatic logic signed [TW-1:0] term(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
        logic signed [TW-1:0] prod;
        prod = a * b;
        return prod >>> FB;
    endfunction

    logic v6_reg;
    meta_t meta6_reg;
    logic signed [TW-1:0] tv6_reg, ts6_reg, tn6_reg, te6_reg, tw6_reg, tp6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta6_reg <= meta5_reg;
            tv6_reg <= term(TW'($signed({1'b0, volume_reg})), TW'(src5_reg));
            ts6_reg <= term(TW'(as5_reg), TW'(xs5_reg));
            tn6_reg <= term(TW'(an5_reg), TW'(xn5_reg));
            te6_reg <= term(TW'(ae5_reg), TW'(xe5_reg));
            tw6_reg <= term(TW'(aw5_reg), TW'(xw5_reg));
            tp6_reg <= term(TW'(ap5_reg), TW'(xp5_reg));
        end
    end

    // ------------------------------------------ stage 7: sum, clamp, output
    logic signed [TW+2:0] res_sum;

    assign res_sum = (TW + 3)'(tv6_reg) + (TW + 3)'(ts6_reg) + (TW + 3)'(tn6_reg)
                   + (TW + 3)'(te6_reg) + (TW + 3)'(tw6_reg) - (TW + 3)'(tp6_reg);

    logic signed [DW-1:0] out_res_reg;
    meta_t out_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg  <= sat(SATW'(res_sum));
            out_meta_reg <= meta6_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_meta_reg.last;
    assign m_tdata  = OUT_W'({out_meta_reg.row, out_meta_reg.col, out_res_reg});

    // ------------------------------------------------------------- checks
    a_col_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_meta_reg.col != '0)
        else $error("residual for a boundary column");

    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && emit1_reg) |-> meta1_reg.row != 16'd0)
        else $error("centre row on padding");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v6_reg))
        else $error("output request without pipeline source");

endmodule

[dv/tb_hybrid_scheme_cd_residual_stencil.sv]
module tb_hybrid_scheme_cd_residual_stencil;
    import hscd_pkg::*;

    localparam int PCOLS = 1024;   // padded column capacity of the line stores
    localparam int IN_W  = 160;
    localparam int OUT_W = 64;
    localparam int DRAIN = 20;     // seven register stages; margin for the tail of a grid

    typedef logic signed [95:0] wide_t;

    typedef struct {
        logic [31:0] residual;
        logic [9:0]  col;
        logic [15:0] row;
        logic        last;
    } residual_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // scalar_value, vel_x, vel_y, diffusivity, source_term (lowest first)
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    // residual, centre_col, centre_row (lowest first); tlast = last_cell
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    hybrid_scheme_cd_residual_stencil dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow of the block: registers, line stores and raster counters
    // ---------------------------------------------------------------
    logic [30:0] dx_r, dy_r, rxy_r, ryx_r, vol_r;
    logic [9:0]  cols_r;
    logic [15:0] rows_r;

    logic [31:0] scal_ln [2*PCOLS];
    logic [31:0] diff_ln [2*PCOLS];
    logic [31:0] vy_ln   [2*PCOLS];
    logic [31:0] vx_ln   [PCOLS];
    logic [31:0] src_ln  [PCOLS];
    logic [31:0] west_vx = '0;
    int unsigned col_ctr = 0;
    int unsigned row_ctr = 0;

    logic [IN_W-1:0] cell_q [$];       // requests waiting for the driver
    residual_t       residual_q [$];   // residuals the block still owes
    int errors = 0;
    int unsigned cyc = 0;

    function automatic wide_t sx32(logic [31:0] v);
        return wide_t'($signed(v));
    endfunction

    function automatic wide_t sat32(wide_t v);
        if (v > 96'sh7FFF_FFFF)
            return 96'sh7FFF_FFFF;
        if (v < -96'sh8000_0000)
            return -96'sh8000_0000;
        return v;
    endfunction

    function automatic wide_t max3(wide_t a, wide_t b, wide_t c);
        wide_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // mean of two face neighbours times a length factor, floored
    function automatic wide_t face_mean(wide_t a, wide_t b, logic [30:0] k);
        wide_t kk;
        kk = $signed({65'd0, k});
        return ((a + b) * kk) >>> 17;
    endfunction

    function automatic wide_t coef_term(wide_t coef, wide_t val);
        return (coef * val) >>> 16;
    endfunction

    // Consume one accepted cell: emit the centre residual if the north
    // neighbour of an interior centre has just arrived, then update the stores.
    task automatic hybrid_residual_step(input logic [IN_W-1:0] d);
        int unsigned nx, ny, w, h, c, r, p, q;
        wide_t xn, xp, xs, xw, xe, nn, np, ns, nw, ne, vn, vp, vs, uw, up, ue, src;
        wide_t fs, fn, fe, fw, ds, dn, de, dw, a_s, a_n, a_e, a_w, a_p, res;
        residual_t exp_r;
        nx = cols_r;
        ny = rows_r;
        if (nx < 1) nx = 1;
        if (nx > PCOLS - 2) nx = PCOLS - 2;
        if (ny < 1) ny = 1;
        w = nx + 2;
        h = ny + 2;
        c = col_ctr;
        r = row_ctr;
        if (c >= w) c = 0;   // counter left outside a shrunk grid restarts
        if (r >= h) r = 0;
        p = (r & 1) * PCOLS;
        q = ((r & 1) ^ 1) * PCOLS;

        if (r >= 2 && c >= 1 && c <= nx)
        begin
            xn = sx32(d[31:0]);    xp = sx32(scal_ln[q+c]); xs = sx32(scal_ln[p+c]);
            xw = sx32(scal_ln[q+c-1]); xe = sx32(scal_ln[q+c+1]);
            nn = sx32(d[127:96]);  np = sx32(diff_ln[q+c]); ns = sx32(diff_ln[p+c]);
            nw = sx32(diff_ln[q+c-1]); ne = sx32(diff_ln[q+c+1]);
            vn = sx32(d[95:64]);   vp = sx32(vy_ln[q+c]);   vs = sx32(vy_ln[p+c]);
            uw = sx32(west_vx);    up = sx32(vx_ln[c]);     ue = sx32(vx_ln[c+1]);
            src = sx32(src_ln[c]);
            fs = face_mean(vs, vp, dx_r);
            fn = face_mean(vn, vp, dx_r);
            fe = face_mean(ue, up, dy_r);
            fw = face_mean(uw, up, dy_r);
            ds = face_mean(np, ns, rxy_r);
            dn = face_mean(np, nn, rxy_r);
            de = face_mean(np, ne, ryx_r);
            dw = face_mean(np, nw, ryx_r);
            a_s = max3(fs, ds + (fs >>> 1), 0);
            a_n = max3(-fn, dn - (fn >>> 1), 0);
            a_e = max3(-fe, de - (fe >>> 1), 0);
            a_w = max3(fw, dw + (fw >>> 1), 0);
            a_p = sat32(fe - fw + fn - fs + a_s + a_n + a_e + a_w);
            res = coef_term($signed({65'd0, vol_r}), src)
                + coef_term(sat32(a_s), xs) + coef_term(sat32(a_n), xn)
                + coef_term(sat32(a_e), xe) + coef_term(sat32(a_w), xw)
                - coef_term(a_p, xp);
            res = sat32(res);
            exp_r.residual = res[31:0];
            exp_r.col      = c[9:0];
            exp_r.row      = 16'(r - 1);
            exp_r.last     = (r - 1 == ny) && (c == nx);
            residual_q.push_back(exp_r);
        end

        west_vx      = vx_ln[c];
        scal_ln[p+c] = d[31:0];
        vx_ln[c]     = d[63:32];
        vy_ln[p+c]   = d[95:64];
        diff_ln[p+c] = d[127:96];
        src_ln[c]    = d[159:128];

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_ctr = c;
        row_ctr = r;
    endtask

    // Random back-pressure: ~15% idle, with a quiet window at the start of each repeating period of cyc
    function automatic logic idle_now();
        return ((cyc % 4000) >= 600) && ($urandom_range(0, 99) < 15);
    endfunction

    always @(posedge clk)
        cyc <= cyc + 1;

    // Driver: one cell request per handshake from cell_q
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                hybrid_residual_step(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (cell_q.size() > 0 && !idle_now())
                begin
                    s_tdata  <= cell_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random stall, compare against the oldest outstanding residual
    always @(posedge clk)
    begin
        residual_t e;
        if (rst_n)
        begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready)
            begin
                if (residual_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected residual, actual %h last %b", $time,
                             m_tdata, m_tlast);
                end
                else
                begin
                    e = residual_q.pop_front();
                    if (m_tdata[31:0] !== e.residual)
                    begin
                        errors++;
                        $display("%0t: residual expected %h actual %h", $time,
                                 e.residual, m_tdata[31:0]);
                    end
                    if (m_tdata[41:32] !== e.col)
                    begin
                        errors++;
                        $display("%0t: centre_col expected %0d actual %0d", $time,
                                 e.col, m_tdata[41:32]);
                    end
                    if (m_tdata[57:42] !== e.row)
                    begin
                        errors++;
                        $display("%0t: centre_row expected %0d actual %0d", $time,
                                 e.row, m_tdata[57:42]);
                    end
                    if (m_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t: last_cell expected %b actual %b", $time,
                                 e.last, m_tlast);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input cfg_index_t idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_STEP_X:    dx_r   = val;
            REG_STEP_Y:    dy_r   = val;
            REG_RATIO_XY:  rxy_r  = val;
            REG_RATIO_YX:  ryx_r  = val;
            REG_VOLUME:    vol_r  = val;
            REG_GRID_COLS: cols_r = val[9:0];
            REG_GRID_ROWS: rows_r = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // unsigned Q15.16 register value: mostly moderate, sometimes an extreme
    function automatic logic [30:0] rand_q16();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 10) return 31'd1;
        if (k < 20) return 31'h7FFF_FFFF;
        return 31'($urandom_range(1, 1 << 18));
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60) return 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
        if (k < 80) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic set_scales(input logic [30:0] v);
        write_reg(REG_STEP_X, v);
        write_reg(REG_STEP_Y, v);
        write_reg(REG_RATIO_XY, v);
        write_reg(REG_RATIO_YX, v);
        write_reg(REG_VOLUME, v);
    endtask

    task automatic rand_scales();
        write_reg(REG_STEP_X, rand_q16());
        write_reg(REG_STEP_Y, rand_q16());
        write_reg(REG_RATIO_XY, rand_q16());
        write_reg(REG_RATIO_YX, rand_q16());
        write_reg(REG_VOLUME, rand_q16());
    endtask

    task automatic set_grid(input logic [9:0] cols, input logic [15:0] rows);
        write_reg(REG_GRID_COLS, 31'(cols));
        write_reg(REG_GRID_ROWS, 31'(rows));
    endtask

    // padded cell count of the current grid (after clamping)
    function automatic int unsigned padded_cells();
        int unsigned nx, ny;
        nx = cols_r;
        ny = rows_r;
        if (nx < 1) nx = 1;
        if (nx > PCOLS - 2) nx = PCOLS - 2;
        if (ny < 1) ny = 1;
        return (nx + 2) * (ny + 2);
    endfunction

    task automatic push_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            cell_q.push_back({rand_word(), rand_word(), rand_word(), rand_word(), rand_word()});
    endtask

    // all requests taken, all residuals back, pipeline tail flushed
    task automatic wait_idle();
        while (cell_q.size() != 0 || s_tvalid)
            @(negedge clk);
        while (residual_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_grid(input logic [9:0] cols, input logic [15:0] rows);
        rand_scales();
        set_grid(cols, rows);
        push_random(padded_cells());
        wait_idle();
    endtask

    initial
    begin
        dx_r = STEP_RESET; dy_r = STEP_RESET; rxy_r = STEP_RESET;
        ryx_r = STEP_RESET; vol_r = STEP_RESET;
        cols_r = COLS_RESET; rows_r = ROWS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid, every field at full scale with largest lengths: saturation
        set_scales(31'h7FFF_FFFF);
        set_grid(10'd1, 16'd1);
        for (int i = 0; i < 9; i++)
            cell_q.push_back({5{(i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000}});
        wait_idle();

        // smallest lengths, mixed extremes and zero per field
        set_scales(31'd1);
        for (int i = 0; i < 9; i++)
            cell_q.push_back({32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                              32'h7FFF_FFFF, (i % 3 == 0) ? 32'h8000_0000 : 32'h0001_0000});
        wait_idle();

        random_grid(10'd16, 16'd16);

        // abandon a grid part way, then shrink it so the row counter falls outside
        rand_scales();
        set_grid(10'd16, 16'd16);
        push_random(5 * 18);
        wait_idle();
        write_reg(REG_GRID_ROWS, 31'd1);
        push_random(padded_cells());
        wait_idle();

        // stop part way along a row, then narrow the grid so only the column restarts
        set_grid(10'd16, 16'd16);
        push_random(3 * 18 + 10);
        wait_idle();
        write_reg(REG_GRID_COLS, 31'd5);
        push_random(7 + 14 * 7);
        wait_idle();

        random_grid(10'd7, 16'd40);
        random_grid(10'd0, 16'd0);      // both clamp to one
        random_grid(10'd3, 16'd5);
        random_grid(10'd30, 16'd10);

        wait_idle();
        if (errors == 0)
            $display("hybrid_scheme_cd_residual_stencil regression: pass");
        else
            $display("hybrid_scheme_cd_residual_stencil regression: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("hybrid_scheme_cd_residual_stencil regression: fail");
        $finish;
    end

endmodule
